### rtl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int HEAP_BYTES_DEF      = 2097152;
  localparam int MIN_BLOCK_BYTES_DEF = 64;
  localparam int NUM_ORDERS_DEF      = 12;

  localparam int REQ_W   = 32;
  localparam int OFF_W   = 21;
  localparam int ORD_W   = 4;
  localparam int USED_W  = 22;
  localparam int CNT_W   = 32;
  localparam int HDR_W   = 6;
  localparam logic [HDR_W-1:0] HDR_RESET = 6'd24;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ZERO      = 3'd1,
    ST_TOO_LARGE = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_NOT_ALLOC = 3'd4
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    TAG_NONE = 2'd0,
    TAG_FREE = 2'd1,
    TAG_USED = 2'd2
  } tag_t;

  typedef struct packed {
    tag_t             tag;
    logic [ORD_W-1:0] order;
  } tag_entry_t;

  typedef struct packed {
    logic next_we;
    logic prev_we;
    logic tag_we;
  } mem_we_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_A_UNLINK,
    S_A_SPLIT,
    S_A_SPLIT2,
    S_A_FIN,
    S_F_CHECK,
    S_F_LOOP,
    S_F_MERGE,
    S_F_PUSH,
    S_F_PUSH2,
    S_DONE
  } state_t;

endpackage

### rtl/bba_ifs.sv
// ----------------------------------------------------------------------------
// bba_ifs
// Request and response channels of the buddy block allocator.
// ----------------------------------------------------------------------------
interface bba_cmd_if import bba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             op;
  logic [REQ_W-1:0] request_bytes;
  logic [OFF_W-1:0] user_offset;

  modport source (output valid, op, request_bytes, user_offset, input ready);
  modport sink   (input valid, op, request_bytes, user_offset, output ready);
endinterface

interface bba_rsp_if import bba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [OFF_W-1:0]  granted_offset;
  logic [ORD_W-1:0]  block_order;
  logic [USED_W-1:0] bytes_in_use;
  logic [CNT_W-1:0]  alloc_total;
  logic [CNT_W-1:0]  free_total;

  modport source (output valid, status, granted_offset, block_order, bytes_in_use,
                  alloc_total, free_total, input ready);
  modport sink   (input valid, status, granted_offset, block_order, bytes_in_use,
                  alloc_total, free_total, output ready);
endinterface

### rtl/bba_slot_store.sv
// ----------------------------------------------------------------------------
// bba_slot_store
// Per-slot memories: next link, prev link and tag/order. One shared read
// address, one write port each, registered read data.
// ----------------------------------------------------------------------------
module bba_slot_store import bba_pkg::*; #(
  parameter int SW = 15
) (
  input  logic          clk,
  input  logic [SW-1:0] rd_addr,
  input  mem_we_t       we,
  input  logic [SW-1:0] next_waddr,
  input  logic [SW:0]   next_wdata,
  input  logic [SW-1:0] prev_waddr,
  input  logic [SW:0]   prev_wdata,
  input  logic [SW-1:0] tag_waddr,
  input  tag_entry_t    tag_wdata,
  output logic [SW:0]   next_rdata,
  output logic [SW:0]   prev_rdata,
  output tag_entry_t    tag_rdata
);

  localparam int DEPTH = 1 << SW;

  logic [SW:0] next_mem [DEPTH];
  logic [SW:0] prev_mem [DEPTH];
  tag_entry_t  tag_mem  [DEPTH];

  always_ff @(posedge clk) begin
    if (we.next_we) next_mem[next_waddr] <= next_wdata;
    next_rdata <= next_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.prev_we) prev_mem[prev_waddr] <= prev_wdata;
    prev_rdata <= prev_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we.tag_we) tag_mem[tag_waddr] <= tag_wdata;
    tag_rdata <= tag_mem[rd_addr];
  end

endmodule

### rtl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: list heads, counters, split/merge steps and the response
// register. Drives the slot memories one access step at a time.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; #(
  parameter int HEAP_BYTES      = HEAP_BYTES_DEF,
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
  parameter int NUM_ORDERS      = NUM_ORDERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [HDR_W-1:0] cfg_wdata,
  bba_cmd_if.sink          cmd,
  bba_rsp_if.source        rsp
);

  localparam int SLOTS    = HEAP_BYTES / MIN_BLOCK_BYTES;
  localparam int SW       = $clog2(SLOTS);
  localparam int MBL      = $clog2(MIN_BLOCK_BYTES);
  localparam int TOP      = NUM_ORDERS - 1;
  localparam int HW       = (NUM_ORDERS > 1) ? $clog2(NUM_ORDERS) : 1;
  localparam int SZ_W     = REQ_W + 2;
  localparam int BOFF_W   = 26;
  localparam logic [SW:0] NONE = {1'b1, {SW{1'b0}}};
  localparam logic [SW:0] LAST_TOP = (SW+1)'(SLOTS - (1 << TOP));
  localparam logic [SW-1:0] TOP_STEP = SW'(1 << TOP);

  state_t state, state_next;

  logic [SW:0]       head [NUM_ORDERS];
  logic [HDR_W-1:0]  hdr;
  logic [USED_W-1:0] used;
  logic [CNT_W-1:0]  acnt, fcnt;
  logic [SW-1:0]     clr;
  logic [ORD_W-1:0]  o, f;
  logic [SW-1:0]     s, nb;
  logic [SW:0]       h;
  status_t           st;
  logic [OFF_W-1:0]  gr;
  logic [ORD_W-1:0]  ord;

  // memory side
  mem_we_t       we;
  logic [SW-1:0] rd_addr, next_waddr, prev_waddr, tag_waddr;
  logic [SW:0]   next_wdata, prev_wdata, next_rdata, prev_rdata;
  tag_entry_t    tag_wdata, tag_rdata;

  logic          head_we;
  logic [HW-1:0] head_widx, head_ridx;
  logic [SW:0]   head_wdata, head_rd;

  bba_slot_store #(.SW(SW)) u_store (
    .clk, .rd_addr, .we, .next_waddr, .next_wdata, .prev_waddr, .prev_wdata,
    .tag_waddr, .tag_wdata, .next_rdata, .prev_rdata, .tag_rdata
  );

  // allocate decode
  logic [SZ_W-1:0]  total;
  logic [ORD_W-1:0] a_o, a_f;
  logic             a_fit, a_found;

  always_comb begin
    total   = SZ_W'(cmd.request_bytes) + SZ_W'(hdr);
    a_o     = '0;
    a_fit   = 1'b0;
    a_f     = '0;
    a_found = 1'b0;
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if ((SZ_W'(MIN_BLOCK_BYTES) << k) >= total) begin
        a_o   = ORD_W'(k);
        a_fit = 1'b1;
      end
    end
    for (int k = NUM_ORDERS - 1; k >= 0; k--) begin
      if (ORD_W'(k) >= a_o && !head[k][SW]) begin
        a_f     = ORD_W'(k);
        a_found = 1'b1;
      end
    end
  end

  // free decode
  logic [BOFF_W-1:0] boff;
  logic              f_ok;
  logic [SW-1:0]     f_slot;

  always_comb begin
    boff   = BOFF_W'(cmd.user_offset) - BOFF_W'(hdr);
    f_ok   = (cmd.user_offset >= OFF_W'(hdr)) && (boff[MBL-1:0] == '0) &&
             (boff < BOFF_W'(HEAP_BYTES));
    f_slot = SW'(boff >> MBL);
  end

  logic [SW-1:0]     bud;
  logic              merge_ok;
  logic [USED_W-1:0] blk_bytes;
  logic [USED_W-1:0] chk_bytes;

  assign bud       = s ^ (SW'(1) << o);
  assign merge_ok  = (tag_rdata.tag == TAG_FREE) && (tag_rdata.order == o);
  assign blk_bytes = USED_W'(SZ_W'(MIN_BLOCK_BYTES) << o);
  assign chk_bytes = USED_W'(SZ_W'(MIN_BLOCK_BYTES) << tag_rdata.order);
  assign head_rd   = head[head_ridx];
  assign cmd.ready = (state == S_IDLE);

  logic acc;
  assign acc = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    we         = '0;
    rd_addr    = s;
    next_waddr = s;
    next_wdata = NONE;
    prev_waddr = s;
    prev_wdata = NONE;
    tag_waddr  = s;
    tag_wdata  = '{tag: TAG_NONE, order: '0};
    head_we    = 1'b0;
    head_widx  = HW'(o);
    head_wdata = NONE;
    head_ridx  = HW'(o);
    case (state)
      S_CLEAR: begin
        we         = '{next_we: 1'b1, prev_we: 1'b1, tag_we: 1'b1};
        next_waddr = clr;
        prev_waddr = clr;
        tag_waddr  = clr;
        // top blocks chained highest offset first
        if (clr[TOP-1:0] == '0) begin
          tag_wdata = '{tag: TAG_FREE, order: ORD_W'(TOP)};
          if (clr != '0) next_wdata = {1'b0, clr - TOP_STEP};
          if ({1'b0, clr} != LAST_TOP) prev_wdata = {1'b0, clr + TOP_STEP};
        end
        if (clr == SW'(SLOTS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        head_ridx = HW'(a_f);
        if (acc) begin
          if (cmd.op == OP_ALLOC) begin
            rd_addr = head_rd[SW-1:0];
            if (cmd.request_bytes == '0 || !a_fit || !a_found) state_next = S_DONE;
            else state_next = S_A_UNLINK;
          end else begin
            rd_addr    = f_slot;
            state_next = f_ok ? S_F_CHECK : S_DONE;
          end
        end
      end
      S_A_UNLINK: begin
        head_we    = 1'b1;
        head_widx  = HW'(f);
        head_wdata = next_rdata;
        if (!next_rdata[SW]) begin
          we.prev_we = 1'b1;
          prev_waddr = next_rdata[SW-1:0];
        end
        state_next = (f > o) ? S_A_SPLIT : S_A_FIN;
      end
      S_A_SPLIT: begin
        head_ridx  = HW'(f - 1'b1);
        we         = '{next_we: 1'b1, prev_we: 1'b1, tag_we: 1'b1};
        next_waddr = s | (SW'(1) << (f - 1'b1));
        next_wdata = head_rd;
        prev_waddr = next_waddr;
        tag_waddr  = next_waddr;
        tag_wdata  = '{tag: TAG_FREE, order: f - 1'b1};
        head_we    = 1'b1;
        head_widx  = HW'(f - 1'b1);
        head_wdata = {1'b0, next_waddr};
        state_next = S_A_SPLIT2;
      end
      S_A_SPLIT2: begin
        if (!h[SW]) begin
          we.prev_we = 1'b1;
          prev_waddr = h[SW-1:0];
          prev_wdata = {1'b0, nb};
        end
        state_next = (f > o) ? S_A_SPLIT : S_A_FIN;
      end
      S_A_FIN: begin
        we.tag_we  = 1'b1;
        tag_wdata  = '{tag: TAG_USED, order: o};
        state_next = S_DONE;
      end
      S_F_CHECK: begin
        if (tag_rdata.tag != TAG_USED || tag_rdata.order > ORD_W'(TOP)) state_next = S_DONE;
        else state_next = S_F_LOOP;
      end
      S_F_LOOP: begin
        rd_addr    = bud;
        state_next = (o < ORD_W'(TOP)) ? S_F_MERGE : S_F_PUSH;
      end
      S_F_MERGE: begin
        if (merge_ok) begin
          if (!prev_rdata[SW]) begin
            we.next_we = 1'b1;
            next_waddr = prev_rdata[SW-1:0];
            next_wdata = next_rdata;
          end else begin
            head_we    = 1'b1;
            head_wdata = next_rdata;
          end
          if (!next_rdata[SW]) begin
            we.prev_we = 1'b1;
            prev_waddr = next_rdata[SW-1:0];
            prev_wdata = prev_rdata;
          end
          // absorbed header goes back to none
          we.tag_we  = 1'b1;
          tag_waddr  = (bud > s) ? bud : s;
          state_next = S_F_LOOP;
        end else begin
          state_next = S_F_PUSH;
        end
      end
      S_F_PUSH: begin
        we         = '{next_we: 1'b1, prev_we: 1'b1, tag_we: 1'b1};
        next_wdata = head_rd;
        tag_wdata  = '{tag: TAG_FREE, order: o};
        head_we    = 1'b1;
        head_wdata = {1'b0, s};
        state_next = S_F_PUSH2;
      end
      S_F_PUSH2: begin
        if (!h[SW]) begin
          we.prev_we = 1'b1;
          prev_waddr = h[SW-1:0];
          prev_wdata = {1'b0, s};
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp.valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_ORDERS; k++) head[k] <= (k == TOP) ? LAST_TOP : NONE;
    end else if (head_we) begin
      head[head_widx] <= head_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hdr  <= HDR_RESET;
      used <= '0;
      acnt <= '0;
      fcnt <= '0;
      clr  <= '0;
    end else begin
      if (cfg_we) hdr <= cfg_wdata;
      if (state == S_CLEAR) clr <= clr + 1'b1;
      if (state == S_A_FIN) begin
        acnt <= acnt + 1'b1;
        used <= used + blk_bytes;
      end
      if (state == S_F_CHECK && tag_rdata.tag == TAG_USED &&
          tag_rdata.order <= ORD_W'(TOP)) begin
        fcnt <= fcnt + 1'b1;
        used <= used - chk_bytes;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        gr  <= '0;
        ord <= '0;
        o   <= a_o;
        f   <= a_f;
        if (cmd.op == OP_ALLOC) begin
          s <= head_rd[SW-1:0];
          if (cmd.request_bytes == '0) st <= ST_ZERO;
          else if (!a_fit)             st <= ST_TOO_LARGE;
          else if (!a_found)           st <= ST_NO_MEM;
          else                         st <= ST_OK;
        end else begin
          s  <= f_slot;
          st <= f_ok ? ST_OK : ST_NOT_ALLOC;
        end
      end
      S_A_SPLIT: begin
        f  <= f - 1'b1;
        h  <= head_rd;
        nb <= s | (SW'(1) << (f - 1'b1));
      end
      S_A_FIN: begin
        ord <= o;
        gr  <= OFF_W'(BOFF_W'(s) * BOFF_W'(MIN_BLOCK_BYTES) + BOFF_W'(hdr));
      end
      S_F_CHECK: begin
        if (tag_rdata.tag != TAG_USED || tag_rdata.order > ORD_W'(TOP)) begin
          st <= ST_NOT_ALLOC;
        end else begin
          o   <= tag_rdata.order;
          ord <= tag_rdata.order;
        end
      end
      S_F_MERGE: begin
        if (merge_ok) begin
          o <= o + 1'b1;
          if (bud < s) s <= bud;
        end
      end
      S_F_PUSH: h <= head_rd;
      default: ;
    endcase
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!rsp.valid || rsp.ready)) begin
      rsp.status         <= st;
      rsp.granted_offset <= gr;
      rsp.block_order    <= ord;
      rsp.bytes_in_use   <= used;
      rsp.alloc_total    <= acnt;
      rsp.free_total     <= fcnt;
    end
  end

  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !(we.next_we || we.prev_we || we.tag_we || head_we))
    else $error("memory write while idle");

  a_split_above: assert property (@(posedge clk) disable iff (rst)
    (state == S_A_SPLIT) |-> (f > o))
    else $error("split below requested order");

  a_merge_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_LOOP) |-> (o <= ORD_W'(TOP)))
    else $error("merge beyond top order");

  a_rd_no_wr: assert property (@(posedge clk) disable iff (rst)
    (state == S_F_LOOP) |=> (state == S_F_PUSH || state == S_F_MERGE))
    else $error("unexpected step after merge lookup");

endmodule

### rtl/buddy_block_allocator_core.sv
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// Buddy allocator over a fixed heap: allocate and free requests, one
// response per request.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  : request channel (op, request_bytes, user_offset), valid/ready.
//   rsp  : response channel (status, offset, order, usage counters).
//   cfg  : cfg_we/cfg_wdata writes header_bytes; write only while idle.
// One request is in flight at a time. An allocate unlinks a free block,
// splits it down to the needed order and marks it used; a free checks
// the tag, merges with each free buddy up to the top order and pushes
// the result on its list. Errors go straight to the response.
// Each merge step is a read then a write of the slot memories, whose
// three memories share one read address; each split step is two writes.
// After reset the slot memories are initialized by a pass over all
// HEAP_BYTES/MIN_BLOCK_BYTES slots (32768 by default); cmd.ready stays low
// meanwhile. A stalled response is held in its register; the next request
// may be accepted and worked on, and its result waits until rsp is free.
// ----------------------------------------------------------------------------
module buddy_block_allocator_core import bba_pkg::*; #(
  parameter int HEAP_BYTES      = HEAP_BYTES_DEF,
  parameter int MIN_BLOCK_BYTES = MIN_BLOCK_BYTES_DEF,
  parameter int NUM_ORDERS      = NUM_ORDERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [HDR_W-1:0] cfg_wdata,
  bba_cmd_if.sink          cmd,
  bba_rsp_if.source        rsp
);

  bba_ctrl #(
    .HEAP_BYTES(HEAP_BYTES),
    .MIN_BLOCK_BYTES(MIN_BLOCK_BYTES),
    .NUM_ORDERS(NUM_ORDERS)
  ) u_ctrl (
    .clk, .rst, .cfg_we, .cfg_wdata, .cmd, .rsp
  );

endmodule
